>>> src/stpsm_pkg.sv
package stpsm_pkg;

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_QUERY = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_LOAD,
    DP_LEAF_SET,
    DP_FILL_LEAF,
    DP_READ_KIDS,
    DP_WRITE_SET,
    DP_WRITE_FILL,
    DP_READ_QRY,
    DP_ACC_QRY,
    DP_FINISH
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic err;
    logic leaf_last;
    logic node_last;
    logic qry_done;
  } dp_status_t;

endpackage

>>> src/segment_tree_prefix_suffix_max.sv
// Segment tree of LEAVES signed values; each node keeps sum, max prefix and
// max suffix. One command per input transfer on the s_ side, one result per
// command on the m_ side.
//   s_tuser[1:0]: 0 set leaf, 1 range query, 2 fill all leaves, 3 no-op.
//   Out-of-range indexes return error set and zeros, and change nothing.
// The tree is stored bottom-up over P = 2^ceil(log2(LEAVES)) leaves in a node
// memory with one write and two registered read ports; every step is a memory
// read followed by a combine or write.
//   set:   write the leaf, then read children and write parent, per level
//   query: two nodes per level, left and right
//   fill:  write leaves, then rebuild each inner node
// Errors and no-ops answer straight from dispatch. One command is in flight at a time;
// s_tready is high only while idle.
// After reset the block clears the tree to zeros, with s_tready low. A stalled
// result holds in the output registers until m_tready.
module segment_tree_prefix_suffix_max #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // first_index[15:0], last_index[31:16], value[47:32]
  input  logic [1:0]  s_tuser,  // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // range_sum[25:0], max_prefix[50:26], max_suffix[75:51], zeros
  output logic [0:0]  m_tuser   // error[0]
);
  import stpsm_pkg::*;

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [25:0] range_sum;
  logic [24:0] max_prefix, max_suffix;
  logic        error;

  stpsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stpsm_dp #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .operation   (s_tuser),
    .first_index (s_tdata[15:0]),
    .last_index  (s_tdata[31:16]),
    .value       (s_tdata[47:32]),
    .status      (status),
    .range_sum   (range_sum),
    .max_prefix  (max_prefix),
    .max_suffix  (max_suffix),
    .error       (error)
  );

  assign m_tdata = {4'b0, max_suffix, max_prefix, range_sum};
  assign m_tuser = error;

endmodule

>>> src/stpsm_dp.sv
module stpsm_dp #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                   clk,
  input  stpsm_pkg::dp_cmd_t     cmd,
  input  logic [1:0]             operation,
  input  logic [15:0]            first_index,
  input  logic [15:0]            last_index,
  input  logic [15:0]            value,
  output stpsm_pkg::dp_status_t  status,
  output logic [25:0]            range_sum,
  output logic [24:0]            max_prefix,
  output logic [24:0]            max_suffix,
  output logic                   error
);
  import stpsm_pkg::*;

  localparam int PB     = $clog2(LEAVES);
  localparam int P      = 1 << PB;
  localparam int ADDR_W = PB + 1;
  localparam int LW     = ADDR_W + 1;
  localparam int SUM_W  = VALUE_BITS + PB + 1;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] pre;
    logic signed [SUM_W-1:0] suf;
  } info_t;

  function automatic logic signed [SUM_W-1:0] max3(logic signed [SUM_W-1:0] a,
                                                   logic signed [SUM_W-1:0] b);
    logic signed [SUM_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > 0) ? m : '0;
  endfunction

  function automatic info_t join_info(info_t lf, info_t rt);
    info_t o;
    o.sum = lf.sum + rt.sum;
    o.pre = max3(lf.pre, lf.sum + rt.pre);
    o.suf = max3(rt.suf, rt.sum + lf.suf);
    return o;
  endfunction

  function automatic info_t leaf_info(logic signed [SUM_W-1:0] v);
    info_t o;
    o.sum = v;
    o.pre = (v > 0) ? v : '0;
    o.suf = o.pre;
    return o;
  endfunction

  info_t mem [2*P];
  info_t rd_a, rd_b, resl, resr, wdata, fin;

  logic [ADDR_W-1:0] idx, waddr, raddr_a, raddr_b;
  logic [LW-1:0]     l, r, rm1;
  logic              we, in_fill_range, load_err;
  logic signed [SUM_W-1:0] val, val_in;
  logic [VALUE_BITS-1:0]   val_low;
  op_t               op, op_in;

  // Take the low value bits as two's complement
  assign val_low = VALUE_BITS'($signed(value));
  assign val_in  = SUM_W'($signed(val_low));
  assign op_in   = op_t'(operation);
  assign rm1     = r - LW'(1);
  assign in_fill_range = (PB+1)'(idx[PB-1:0]) < (PB+1)'(LEAVES);

  always_comb begin
    case (op_in)
      OP_SET:   load_err = {1'b0, first_index} >= 17'(LEAVES);
      OP_QUERY: load_err = ({1'b0, first_index} >= 17'(LEAVES)) ||
                           ({1'b0, last_index} >= 17'(LEAVES));
      default:  load_err = 1'b0;
    endcase
  end

  // Write port and read addresses
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = leaf_info(val);
    case (cmd)
      DP_LEAF_SET: we = 1'b1;
      DP_FILL_LEAF: begin
        we    = 1'b1;
        wdata = in_fill_range ? leaf_info(val) : '0;
      end
      DP_WRITE_SET, DP_WRITE_FILL: begin
        we    = 1'b1;
        wdata = join_info(rd_a, rd_b);
      end
      default: we = 1'b0;
    endcase
    if (cmd == DP_READ_QRY) begin
      raddr_a = l[ADDR_W-1:0];
      raddr_b = rm1[ADDR_W-1:0];
    end else begin
      raddr_a = {idx[ADDR_W-2:0], 1'b0};
      raddr_b = {idx[ADDR_W-2:0], 1'b1};
    end
  end

  // Node memory: one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  assign fin = join_info(resl, resr);

  // Index walk, query accumulation and result registers
  always_ff @(posedge clk) begin
    case (cmd)
      DP_CLEAR: begin
        val <= '0;
        idx <= ADDR_W'(P);
      end
      DP_LOAD: begin
        op         <= op_in;
        val        <= val_in;
        error      <= load_err;
        range_sum  <= '0;
        max_prefix <= '0;
        max_suffix <= '0;
        resl       <= '0;
        resr       <= '0;
        idx <= (op_in == OP_FILL) ? ADDR_W'(P) : ADDR_W'(P) + ADDR_W'(first_index[PB-1:0]);
        l   <= LW'(P) + LW'(first_index[PB-1:0]);
        r   <= LW'(P) + LW'(last_index[PB-1:0]) + LW'(1);
      end
      DP_LEAF_SET, DP_WRITE_SET: idx <= idx >> 1;
      DP_FILL_LEAF: idx <= (&idx) ? ADDR_W'(P - 1) : idx + ADDR_W'(1);
      DP_WRITE_FILL: idx <= idx - ADDR_W'(1);
      DP_ACC_QRY: begin
        if (l[0]) resl <= join_info(resl, rd_a);
        if (r[0]) resr <= join_info(rd_b, resr);
        l <= (l + LW'(l[0])) >> 1;
        r <= r >> 1;
      end
      DP_FINISH: begin
        range_sum  <= 26'(fin.sum);
        max_prefix <= 25'(fin.pre);
        max_suffix <= 25'(fin.suf);
      end
      default: idx <= idx;
    endcase
  end

  assign status.op        = op;
  assign status.err       = error;
  assign status.leaf_last = &idx;
  assign status.node_last = idx == ADDR_W'(1);
  assign status.qry_done  = l >= r;

endmodule

>>> src/stpsm_ctrl.sv
module stpsm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  stpsm_pkg::dp_status_t status,
  output stpsm_pkg::dp_cmd_t    cmd
);
  import stpsm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SET_LEAF, S_SET_RD, S_SET_WR,
    S_FILL_LEAF, S_FILL_RD, S_FILL_WR, S_QRY_CHK, S_QRY_ACC, S_QRY_FIN, S_OUT
  } state_t;

  state_t state;
  logic   clearing;

  assign s_tready = state == S_IDLE;

  // Command decode
  always_comb begin
    case (state)
      S_CLEAR:     cmd = DP_CLEAR;
      S_IDLE:      cmd = s_tvalid ? DP_LOAD : DP_IDLE;
      S_SET_LEAF:  cmd = DP_LEAF_SET;
      S_SET_RD:    cmd = DP_READ_KIDS;
      S_SET_WR:    cmd = DP_WRITE_SET;
      S_FILL_LEAF: cmd = DP_FILL_LEAF;
      S_FILL_RD:   cmd = DP_READ_KIDS;
      S_FILL_WR:   cmd = DP_WRITE_FILL;
      S_QRY_CHK:   cmd = status.qry_done ? DP_IDLE : DP_READ_QRY;
      S_QRY_ACC:   cmd = DP_ACC_QRY;
      S_QRY_FIN:   cmd = DP_FINISH;
      default:     cmd = DP_IDLE;
    endcase
  end

  // Sequence each operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clearing <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: state <= S_FILL_LEAF;
        S_IDLE: if (s_tvalid) state <= S_DISPATCH;
        S_DISPATCH: begin
          if (status.err || status.op == OP_NONE) begin
            state    <= S_OUT;
            m_tvalid <= 1'b1;
          end else if (status.op == OP_SET) begin
            state <= S_SET_LEAF;
          end else if (status.op == OP_FILL) begin
            state <= S_FILL_LEAF;
          end else begin
            state <= S_QRY_CHK;
          end
        end
        S_SET_LEAF: state <= S_SET_RD;
        S_SET_RD:   state <= S_SET_WR;
        S_SET_WR: begin
          if (status.node_last) begin
            state    <= S_OUT;
            m_tvalid <= 1'b1;
          end else begin
            state <= S_SET_RD;
          end
        end
        S_FILL_LEAF: if (status.leaf_last) state <= S_FILL_RD;
        S_FILL_RD:   state <= S_FILL_WR;
        S_FILL_WR: begin
          if (!status.node_last) begin
            state <= S_FILL_RD;
          end else if (clearing) begin
            state    <= S_IDLE;
            clearing <= 1'b0;
          end else begin
            state    <= S_OUT;
            m_tvalid <= 1'b1;
          end
        end
        S_QRY_CHK: state <= status.qry_done ? S_QRY_FIN : S_QRY_ACC;
        S_QRY_ACC: state <= S_QRY_CHK;
        S_QRY_FIN: begin
          state    <= S_OUT;
          m_tvalid <= 1'b1;
        end
        S_OUT: begin
          if (m_tready) begin
            state    <= S_IDLE;
            m_tvalid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
